// File: design/timer_deadline_list_manager_assert.svh
// Assertion macros for the timer list manager.
`ifndef TIMER_DEADLINE_LIST_MANAGER_ASSERT_SVH
`define TIMER_DEADLINE_LIST_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define TDLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDLM_ASSERT(lbl, prop, msg)
`define TDLM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: design/tdlm_pkg.sv
package tdlm_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int NUM_QUEUES = 16;

  localparam int ID_W   = 5;
  localparam int Q_W    = 4;
  localparam int DL_W   = 32;
  localparam int DATA_W = 32;
  localparam int SLOT_W = $clog2(NUM_TIMERS);
  localparam int LINK_W = SLOT_W + 1;

  localparam logic [LINK_W-1:0] SENT = LINK_W'(NUM_TIMERS);
  localparam logic [DL_W-1:0]   ALL_ONES = '1;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_SETINFO = 3'd2,
    OP_SETTIME = 3'd3,
    OP_FREE    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    K_DONE   = 3'd0,
    K_EXPIRY = 3'd1,
    K_ALLOC  = 3'd2,
    K_NOSLOT = 3'd3,
    K_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } st_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT,
    S_T_RD, S_T_CHK, S_T_END,
    S_INS_RD, S_INS_HEAD, S_NX_RD, S_NX_CHK, S_HEADW, S_W1, S_W2,
    S_FR_RD, S_FR_CHK, S_FR_TRD, S_FR_TCHK
  } state_t;

  typedef struct packed {
    logic                     vld;
    kind_t                    kind;
    logic [ID_W-1:0]          slot;
    logic [Q_W-1:0]           queue;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } res_t;

endpackage

// File: design/tdlm_ram.sv
module tdlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/tdlm_out.sv
module tdlm_out (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tdlm_pkg::res_t                         res,
  output logic                                   ready,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [2:0]                             out_kind,
  output logic [tdlm_pkg::ID_W-1:0]              out_slot,
  output logic [tdlm_pkg::Q_W-1:0]               out_dest_queue,
  output logic signed [tdlm_pkg::DATA_W-1:0]     out_event_data,
  output logic                                   out_last
);

  logic           valid_r;
  tdlm_pkg::res_t data_r;

  assign ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= res.vld;
    end
    if (ready && res.vld) begin
      data_r <= res;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = 3'(data_r.kind);
  assign out_slot       = data_r.slot;
  assign out_dest_queue = data_r.queue;
  assign out_event_data = data_r.data;
  assign out_last       = data_r.last;

endmodule

// File: design/tdlm_seq.sv
`include "timer_deadline_list_manager_assert.svh"

module tdlm_seq (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            in_opcode,
  input  logic [tdlm_pkg::ID_W-1:0]             in_timer_id,
  input  logic [tdlm_pkg::DL_W-1:0]             in_delay,
  input  logic [tdlm_pkg::Q_W-1:0]              in_queue_id,
  input  logic signed [tdlm_pkg::DATA_W-1:0]    in_payload,
  // list memory: {deadline, next}
  output logic [tdlm_pkg::SLOT_W-1:0]           rd_addr,
  output logic                                  lst_we,
  output logic [tdlm_pkg::SLOT_W-1:0]           lst_waddr,
  output logic [tdlm_pkg::DL_W+tdlm_pkg::LINK_W-1:0] lst_wdata,
  input  logic [tdlm_pkg::DL_W+tdlm_pkg::LINK_W-1:0] lst_rdata,
  // info memory: {queue, data}
  output logic                                  inf_we,
  output logic [tdlm_pkg::SLOT_W-1:0]           inf_waddr,
  output logic [tdlm_pkg::Q_W+tdlm_pkg::DATA_W-1:0] inf_wdata,
  input  logic [tdlm_pkg::Q_W+tdlm_pkg::DATA_W-1:0] inf_rdata,
  output tdlm_pkg::res_t                        res,
  input  logic                                  can_emit
);

  localparam int SW = tdlm_pkg::SLOT_W;
  localparam int LW = tdlm_pkg::LINK_W;
  localparam int DW = tdlm_pkg::DL_W;

  function automatic logic [LW-1:0] clamp(input logic [LW-1:0] l);
    clamp = (l >= tdlm_pkg::SENT) ? tdlm_pkg::SENT : l;
  endfunction

  tdlm_pkg::state_t state_r, state_nxt;
  logic [DW-1:0]    tick_r, tick_nxt;
  logic [DW-1:0]    early_r, early_nxt;
  logic [LW-1:0]    head_r, head_nxt;
  tdlm_pkg::st_t    status_r [tdlm_pkg::NUM_TIMERS];
  tdlm_pkg::st_t    status_nxt [tdlm_pkg::NUM_TIMERS];
  logic [tdlm_pkg::NUM_TIMERS-1:0] ivld_r, ivld_nxt;
  logic [SW-1:0]    tid_r, tid_nxt;
  logic [DW-1:0]    dl_r, dl_nxt;
  logic [SW-1:0]    prev_r, prev_nxt;
  logic [DW-1:0]    prev_dl_r, prev_dl_nxt;
  logic [LW-1:0]    nx_r, nx_nxt;
  logic             unl_head_r, unl_head_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [SW-1:0]    pend_slot_r, pend_slot_nxt;
  logic [tdlm_pkg::Q_W-1:0]    pend_q_r, pend_q_nxt;
  logic [tdlm_pkg::DATA_W-1:0] pend_d_r, pend_d_nxt;
  tdlm_pkg::kind_t  res_kind_r, res_kind_nxt;
  logic [SW-1:0]    res_slot_r, res_slot_nxt;

  logic [DW-1:0]    r_dl;
  logic [LW-1:0]    r_nx;
  logic [tdlm_pkg::Q_W-1:0]    r_q;
  logic [tdlm_pkg::DATA_W-1:0] r_d;
  logic [DW-1:0]    tick_inc;
  logic [SW-1:0]    t_in;
  logic             id_ok;
  logic             free_found;
  logic [SW-1:0]    free_idx;
  logic             expire;
  logic             t_go;

  assign r_dl     = lst_rdata[DW+LW-1:LW];
  assign r_nx     = lst_rdata[LW-1:0];
  assign r_q      = inf_rdata[tdlm_pkg::Q_W+tdlm_pkg::DATA_W-1:tdlm_pkg::DATA_W];
  assign r_d      = inf_rdata[tdlm_pkg::DATA_W-1:0];
  assign tick_inc = tick_r + DW'(1);
  assign t_in     = in_timer_id[SW-1:0];
  assign id_ok    = int'(in_timer_id) < tdlm_pkg::NUM_TIMERS;
  assign expire   = r_dl <= tick_r;
  // a previous expiry still has to go out before the next is taken
  assign t_go     = !(pend_v_r && !can_emit);
  assign in_stall = (state_r != tdlm_pkg::S_IDLE);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = tdlm_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
      if (status_r[i] == tdlm_pkg::ST_FREE) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdlm_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            tdlm_pkg::OP_TICK: begin
              if (early_r > tick_inc) state_nxt = tdlm_pkg::S_EMIT;
              else if (head_r == tdlm_pkg::SENT) state_nxt = tdlm_pkg::S_T_END;
              else state_nxt = tdlm_pkg::S_T_RD;
            end
            tdlm_pkg::OP_SETTIME: begin
              if (!id_ok || status_r[t_in] != tdlm_pkg::ST_ALLOC)
                state_nxt = tdlm_pkg::S_EMIT;
              else if (head_r == tdlm_pkg::SENT) state_nxt = tdlm_pkg::S_HEADW;
              else state_nxt = tdlm_pkg::S_INS_RD;
            end
            tdlm_pkg::OP_FREE: begin
              if (!id_ok || status_r[t_in] != tdlm_pkg::ST_RUN)
                state_nxt = tdlm_pkg::S_EMIT;
              else if (head_r == LW'(t_in)) state_nxt = tdlm_pkg::S_FR_TRD;
              else state_nxt = tdlm_pkg::S_FR_RD;
            end
            default: state_nxt = tdlm_pkg::S_EMIT;
          endcase
        end
      end
      tdlm_pkg::S_EMIT:     if (can_emit) state_nxt = tdlm_pkg::S_IDLE;
      tdlm_pkg::S_T_RD:     state_nxt = tdlm_pkg::S_T_CHK;
      tdlm_pkg::S_T_CHK: begin
        if (!expire) state_nxt = tdlm_pkg::S_T_END;
        else if (t_go) begin
          state_nxt = (clamp(r_nx) == tdlm_pkg::SENT) ? tdlm_pkg::S_T_END
                                                      : tdlm_pkg::S_T_RD;
        end
      end
      tdlm_pkg::S_T_END:    if (can_emit) state_nxt = tdlm_pkg::S_IDLE;
      tdlm_pkg::S_INS_RD:   state_nxt = tdlm_pkg::S_INS_HEAD;
      tdlm_pkg::S_INS_HEAD: begin
        if (dl_r <= r_dl) state_nxt = tdlm_pkg::S_HEADW;
        else if (r_nx >= tdlm_pkg::SENT) state_nxt = tdlm_pkg::S_W1;
        else state_nxt = tdlm_pkg::S_NX_RD;
      end
      tdlm_pkg::S_NX_RD:    state_nxt = tdlm_pkg::S_NX_CHK;
      tdlm_pkg::S_NX_CHK: begin
        if (dl_r < r_dl) state_nxt = tdlm_pkg::S_W1;
        else if (r_nx >= tdlm_pkg::SENT) state_nxt = tdlm_pkg::S_W1;
        else state_nxt = tdlm_pkg::S_NX_RD;
      end
      tdlm_pkg::S_HEADW:    state_nxt = tdlm_pkg::S_EMIT;
      tdlm_pkg::S_W1:       state_nxt = tdlm_pkg::S_W2;
      tdlm_pkg::S_W2:       state_nxt = tdlm_pkg::S_EMIT;
      tdlm_pkg::S_FR_RD:    state_nxt = tdlm_pkg::S_FR_CHK;
      tdlm_pkg::S_FR_CHK: begin
        if (r_nx == LW'(tid_r)) state_nxt = tdlm_pkg::S_FR_TRD;
        else if (r_nx >= tdlm_pkg::SENT) state_nxt = tdlm_pkg::S_EMIT;
        else state_nxt = tdlm_pkg::S_FR_RD;
      end
      tdlm_pkg::S_FR_TRD:   state_nxt = tdlm_pkg::S_FR_TCHK;
      tdlm_pkg::S_FR_TCHK:  state_nxt = tdlm_pkg::S_EMIT;
      default:              state_nxt = tdlm_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    tick_nxt     = tick_r;
    early_nxt    = early_r;
    head_nxt     = head_r;
    status_nxt   = status_r;
    ivld_nxt     = ivld_r;
    tid_nxt      = tid_r;
    dl_nxt       = dl_r;
    prev_nxt     = prev_r;
    prev_dl_nxt  = prev_dl_r;
    nx_nxt       = nx_r;
    unl_head_nxt = unl_head_r;
    pend_v_nxt   = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_q_nxt   = pend_q_r;
    pend_d_nxt   = pend_d_r;
    res_kind_nxt = res_kind_r;
    res_slot_nxt = res_slot_r;
    rd_addr      = head_r[SW-1:0];
    lst_we       = 1'b0;
    lst_waddr    = tid_r;
    lst_wdata    = {dl_r, nx_r};
    inf_we       = 1'b0;
    inf_waddr    = t_in;
    inf_wdata    = {in_queue_id, in_payload};
    res          = '0;

    case (state_r)
      tdlm_pkg::S_IDLE: begin
        if (in_valid) begin
          res_kind_nxt = tdlm_pkg::K_DONE;
          res_slot_nxt = '0;
          tid_nxt      = t_in;
          case (in_opcode)
            tdlm_pkg::OP_TICK: tick_nxt = tick_inc;
            tdlm_pkg::OP_ALLOC: begin
              if (free_found) begin
                status_nxt[free_idx] = tdlm_pkg::ST_ALLOC;
                res_kind_nxt = tdlm_pkg::K_ALLOC;
                res_slot_nxt = free_idx;
              end else begin
                res_kind_nxt = tdlm_pkg::K_NOSLOT;
              end
            end
            tdlm_pkg::OP_SETINFO: begin
              if (!id_ok || int'(in_queue_id) >= tdlm_pkg::NUM_QUEUES) begin
                res_kind_nxt = tdlm_pkg::K_ERROR;
              end else begin
                inf_we         = 1'b1;
                ivld_nxt[t_in] = 1'b1;
              end
            end
            tdlm_pkg::OP_SETTIME: begin
              if (!id_ok || status_r[t_in] != tdlm_pkg::ST_ALLOC) begin
                res_kind_nxt = tdlm_pkg::K_ERROR;
              end else begin
                status_nxt[t_in] = tdlm_pkg::ST_RUN;
                dl_nxt = tick_r + in_delay;
              end
            end
            tdlm_pkg::OP_FREE: begin
              if (!id_ok) begin
                res_kind_nxt = tdlm_pkg::K_ERROR;
              end else begin
                status_nxt[t_in] = tdlm_pkg::ST_FREE;
                prev_nxt     = head_r[SW-1:0];
                unl_head_nxt = (head_r == LW'(t_in));
              end
            end
            default: res_kind_nxt = tdlm_pkg::K_ERROR;
          endcase
        end
      end
      tdlm_pkg::S_EMIT: begin
        res.vld  = can_emit;
        res.kind = res_kind_r;
        res.slot = res_slot_r;
        res.last = 1'b1;
      end
      tdlm_pkg::S_T_CHK: begin
        if (!expire) begin
          early_nxt = r_dl;
        end else if (t_go) begin
          if (pend_v_r) begin
            res.vld   = 1'b1;
            res.kind  = tdlm_pkg::K_EXPIRY;
            res.slot  = pend_slot_r;
            res.queue = pend_q_r;
            res.data  = pend_d_r;
          end
          status_nxt[head_r[SW-1:0]] = tdlm_pkg::ST_FREE;
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = head_r[SW-1:0];
          pend_q_nxt    = ivld_r[head_r[SW-1:0]] ? r_q : '0;
          pend_d_nxt    = ivld_r[head_r[SW-1:0]] ? r_d : '1;
          head_nxt      = clamp(r_nx);
        end
      end
      tdlm_pkg::S_T_END: begin
        if (head_r == tdlm_pkg::SENT) early_nxt = tdlm_pkg::ALL_ONES;
        if (can_emit) begin
          res.vld  = 1'b1;
          res.last = 1'b1;
          if (pend_v_r) begin
            res.kind  = tdlm_pkg::K_EXPIRY;
            res.slot  = pend_slot_r;
            res.queue = pend_q_r;
            res.data  = pend_d_r;
          end else begin
            res.kind = tdlm_pkg::K_DONE;
          end
          pend_v_nxt = 1'b0;
        end
      end
      tdlm_pkg::S_INS_HEAD: begin
        prev_nxt    = head_r[SW-1:0];
        prev_dl_nxt = r_dl;
        nx_nxt      = clamp(r_nx);
      end
      tdlm_pkg::S_NX_RD: rd_addr = nx_r[SW-1:0];
      tdlm_pkg::S_NX_CHK: begin
        rd_addr = nx_r[SW-1:0];
        if (!(dl_r < r_dl)) begin
          prev_nxt    = nx_r[SW-1:0];
          prev_dl_nxt = r_dl;
          nx_nxt      = clamp(r_nx);
        end
      end
      tdlm_pkg::S_HEADW: begin
        lst_we    = 1'b1;
        lst_wdata = {dl_r, head_r};
        head_nxt  = LW'(tid_r);
        early_nxt = dl_r;
      end
      tdlm_pkg::S_W1: lst_we = 1'b1;
      tdlm_pkg::S_W2: begin
        lst_we    = 1'b1;
        lst_waddr = prev_r;
        lst_wdata = {prev_dl_r, LW'(tid_r)};
      end
      tdlm_pkg::S_FR_RD: rd_addr = prev_r;
      tdlm_pkg::S_FR_CHK: begin
        rd_addr = prev_r;
        if (r_nx == LW'(tid_r)) prev_dl_nxt = r_dl;
        else if (r_nx < tdlm_pkg::SENT) prev_nxt = r_nx[SW-1:0];
      end
      tdlm_pkg::S_FR_TRD: rd_addr = tid_r;
      tdlm_pkg::S_FR_TCHK: begin
        rd_addr = tid_r;
        if (unl_head_r) begin
          head_nxt = clamp(r_nx);
        end else begin
          lst_we    = 1'b1;
          lst_waddr = prev_r;
          lst_wdata = {prev_dl_r, clamp(r_nx)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tdlm_pkg::S_IDLE;
      tick_r   <= '0;
      early_r  <= tdlm_pkg::ALL_ONES;
      head_r   <= tdlm_pkg::SENT;
      ivld_r   <= '0;
      pend_v_r <= 1'b0;
      for (int i = 0; i < tdlm_pkg::NUM_TIMERS; i++) begin
        status_r[i] <= tdlm_pkg::ST_FREE;
      end
    end else begin
      state_r  <= state_nxt;
      tick_r   <= tick_nxt;
      early_r  <= early_nxt;
      head_r   <= head_nxt;
      ivld_r   <= ivld_nxt;
      pend_v_r <= pend_v_nxt;
      status_r <= status_nxt;
    end
    tid_r       <= tid_nxt;
    dl_r        <= dl_nxt;
    prev_r      <= prev_nxt;
    prev_dl_r   <= prev_dl_nxt;
    nx_r        <= nx_nxt;
    unl_head_r  <= unl_head_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_q_r    <= pend_q_nxt;
    pend_d_r    <= pend_d_nxt;
    res_kind_r  <= res_kind_nxt;
    res_slot_r  <= res_slot_nxt;
  end

  `TDLM_ASSERT(a_head_range, head_r <= tdlm_pkg::SENT, "head link past sentinel")
  `TDLM_ASSERT(a_emit_ready, res.vld |-> can_emit, "result pushed into full output")
  `TDLM_ASSERT(a_idle_no_pend, state_r == tdlm_pkg::S_IDLE |-> !pend_v_r, "expiry left behind")
  `TDLM_ASSERT_ALWAYS(a_rst, !rst_n |=> (state_r == tdlm_pkg::S_IDLE && !pend_v_r), "bad reset")

endmodule

// File: design/timer_deadline_list_manager.sv
// Deadline-sorted timer list manager.
// Input channel (in_valid/in_stall): one command item per accept: tick,
// allocate, set info, set time or free. Result channel (out_valid/out_stall):
// each command yields one result, a tick yields one expiry item per expired
// timer in deadline order (out_last on the final one) or a single done item.
// Allocate, set info and errors need no list walk. Set time and free walk the
// list an entry per step and a tick steps once per expired timer; every step of
// a list walk goes through the registered read of the list memory.
// One command is in work at a time; in_stall is high until its last result
// has entered the output register, which holds while out_stall is high.
// Reset (synchronous, active low) empties the list, frees all slots, clears
// the tick count and sets queue/data of every slot to 0/all ones; the list
// memory needs no clearing pass, since only linked entries are ever read.
module timer_deadline_list_manager (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_opcode,
  input  logic [tdlm_pkg::ID_W-1:0]          in_timer_id,
  input  logic [tdlm_pkg::DL_W-1:0]          in_delay,
  input  logic [tdlm_pkg::Q_W-1:0]           in_queue_id,
  input  logic signed [tdlm_pkg::DATA_W-1:0] in_payload,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_kind,
  output logic [tdlm_pkg::ID_W-1:0]          out_slot,
  output logic [tdlm_pkg::Q_W-1:0]           out_dest_queue,
  output logic signed [tdlm_pkg::DATA_W-1:0] out_event_data,
  output logic                               out_last
);

  localparam int LST_W = tdlm_pkg::DL_W + tdlm_pkg::LINK_W;
  localparam int INF_W = tdlm_pkg::Q_W + tdlm_pkg::DATA_W;

  logic [tdlm_pkg::SLOT_W-1:0] rd_addr;
  logic                        lst_we;
  logic [tdlm_pkg::SLOT_W-1:0] lst_waddr;
  logic [LST_W-1:0]            lst_wdata, lst_rdata;
  logic                        inf_we;
  logic [tdlm_pkg::SLOT_W-1:0] inf_waddr;
  logic [INF_W-1:0]            inf_wdata, inf_rdata;
  tdlm_pkg::res_t              res;
  logic                        can_emit;

  tdlm_seq u_seq (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_timer_id,
    .in_delay, .in_queue_id, .in_payload,
    .rd_addr, .lst_we, .lst_waddr, .lst_wdata, .lst_rdata,
    .inf_we, .inf_waddr, .inf_wdata, .inf_rdata,
    .res, .can_emit
  );

  tdlm_ram #(.WIDTH(LST_W), .DEPTH(tdlm_pkg::NUM_TIMERS)) u_lst_ram (
    .clk, .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .raddr(rd_addr), .rdata(lst_rdata)
  );

  tdlm_ram #(.WIDTH(INF_W), .DEPTH(tdlm_pkg::NUM_TIMERS)) u_inf_ram (
    .clk, .we(inf_we), .waddr(inf_waddr), .wdata(inf_wdata),
    .raddr(rd_addr), .rdata(inf_rdata)
  );

  tdlm_out u_out (
    .clk, .rst_n, .res, .ready(can_emit), .out_valid, .out_stall,
    .out_kind, .out_slot, .out_dest_queue, .out_event_data, .out_last
  );

endmodule

// File: tb/timer_deadline_list_manager_test.sv
module timer_deadline_list_manager_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 312;
  localparam int NT       = tdlm_pkg::NUM_TIMERS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic [tdlm_pkg::ID_W-1:0] in_timer_id = '0;
  logic [tdlm_pkg::DL_W-1:0] in_delay = '0;
  logic [tdlm_pkg::Q_W-1:0] in_queue_id = '0;
  logic signed [tdlm_pkg::DATA_W-1:0] in_payload = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [tdlm_pkg::ID_W-1:0] out_slot;
  logic [tdlm_pkg::Q_W-1:0] out_dest_queue;
  logic signed [tdlm_pkg::DATA_W-1:0] out_event_data;
  logic out_last;

  timer_deadline_list_manager dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  typedef struct {
    logic [2:0] op;
    logic [4:0] id;
    logic [31:0] dly;
    logic [3:0] q;
    logic [31:0] pl;
  } cmd_t;

  typedef struct {
    logic [2:0] kind;
    logic [4:0] slot;
    logic [3:0] q;
    logic [31:0] data;
    logic last;
  } rsp_t;

  typedef struct {
    cmd_t c;
    bit   has_exp;
    rsp_t exp;
  } row_t;

  // predictor state
  logic [31:0] ticks;
  logic [31:0] earliest;
  int unsigned head;
  tdlm_pkg::st_t status[NT];
  logic [31:0] dline[NT];
  int unsigned nxt[NT];
  logic [3:0] squeue[NT];
  logic [31:0] sdata[NT];

  rsp_t pending[$];
  row_t dir_rows[$];
  int errors = 0;
  int n_expiries = 0;
  int n_items = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic logic [31:0] dl_at(int unsigned i);
    return (i >= NT) ? tdlm_pkg::ALL_ONES : dline[i];
  endfunction

  function automatic void push(logic [2:0] k, logic [4:0] s = 5'd0, logic [3:0] q = 4'd0,
                               logic [31:0] d = 32'd0, logic l = 1'b1);
    rsp_t r;
    r.kind = k; r.slot = s; r.q = q; r.data = d; r.last = l;
    pending.push_back(r);
  endfunction

  function automatic void predict(cmd_t c);
    int unsigned p, nx;
    int n;
    logic [31:0] d;
    case (c.op)
      tdlm_pkg::OP_TICK: begin
        ticks++;
        if (earliest > ticks) begin
          push(tdlm_pkg::K_DONE);
        end else begin
          n = 0;
          while (head < NT && dline[head] <= ticks) begin
            push(tdlm_pkg::K_EXPIRY, 5'(head), squeue[head], sdata[head], 1'b0);
            n++;
            status[head] = tdlm_pkg::ST_FREE;
            head = nxt[head];
          end
          earliest = dl_at(head);
          n_expiries += n;
          if (n == 0) push(tdlm_pkg::K_DONE);
          else pending[$].last = 1'b1;
        end
      end
      tdlm_pkg::OP_ALLOC: begin
        for (int i = 0; i < NT; i++) begin
          if (status[i] == tdlm_pkg::ST_FREE) begin
            status[i] = tdlm_pkg::ST_ALLOC;
            push(tdlm_pkg::K_ALLOC, 5'(i));
            return;
          end
        end
        push(tdlm_pkg::K_NOSLOT);
      end
      tdlm_pkg::OP_SETINFO: begin
        squeue[c.id] = c.q;
        sdata[c.id] = c.pl;
        push(tdlm_pkg::K_DONE);
      end
      tdlm_pkg::OP_SETTIME: begin
        if (status[c.id] != tdlm_pkg::ST_ALLOC) begin
          push(tdlm_pkg::K_ERROR);
          return;
        end
        d = c.dly + ticks;
        dline[c.id] = d;
        status[c.id] = tdlm_pkg::ST_RUN;
        if (d <= dl_at(head)) begin
          nxt[c.id] = head;
          head = 32'(c.id);
          earliest = d;
        end else begin
          p = head;
          forever begin
            nx = nxt[p];
            if (nx >= NT || d < dline[nx]) begin
              nxt[c.id] = (nx >= NT) ? NT : nx;
              nxt[p] = 32'(c.id);
              break;
            end
            p = nx;
          end
        end
        push(tdlm_pkg::K_DONE);
      end
      tdlm_pkg::OP_FREE: begin
        if (status[c.id] == tdlm_pkg::ST_RUN) begin
          if (head == c.id) begin
            head = nxt[c.id];
          end else begin
            p = head;
            while (p < NT) begin
              if (nxt[p] == c.id) begin
                nxt[p] = nxt[c.id];
                break;
              end
              p = nxt[p];
            end
          end
        end
        status[c.id] = tdlm_pkg::ST_FREE;
        push(tdlm_pkg::K_DONE);
      end
      default: push(tdlm_pkg::K_ERROR);
    endcase
  endfunction

  function automatic cmd_t mk(logic [2:0] op, logic [4:0] id = 5'd0, logic [31:0] dly = 32'd0,
                              logic [3:0] q = 4'd0, logic [31:0] pl = 32'd0);
    cmd_t c;
    c.op = op; c.id = id; c.dly = dly; c.q = q; c.pl = pl;
    return c;
  endfunction

  // row checked against the predictor
  function automatic void add(cmd_t c);
    row_t w;
    w.c = c;
    w.has_exp = 1'b0;
    w.exp = '{default: '0};
    dir_rows.push_back(w);
  endfunction

  // row with its single result typed in
  function automatic void add_exp(cmd_t c, logic [2:0] k, logic [4:0] s = 5'd0);
    row_t w;
    w.c = c;
    w.has_exp = 1'b1;
    w.exp = '{default: '0};
    w.exp.kind = k;
    w.exp.slot = s;
    w.exp.last = 1'b1;
    dir_rows.push_back(w);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c.id = 5'($urandom_range(0, 31));
    c.q = 4'($urandom);
    c.pl = $urandom;
    r = $urandom_range(0, 9);
    if (r < 7) c.dly = $urandom_range(0, 12);
    else if (r < 9) c.dly = $urandom;
    else c.dly = tdlm_pkg::ALL_ONES - ticks;
    r = $urandom_range(0, 99);
    if (r < 3) c.op = 3'($urandom_range(5, 7));
    else if (r < 33) c.op = tdlm_pkg::OP_TICK;
    else if (r < 50) c.op = tdlm_pkg::OP_ALLOC;
    else if (r < 62) c.op = tdlm_pkg::OP_SETINFO;
    else if (r < 88) c.op = tdlm_pkg::OP_SETTIME;
    else c.op = tdlm_pkg::OP_FREE;
    return c;
  endfunction

  // idle gap between bursts of random length
  task automatic gap();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic send(input row_t w);
    predict(w.c);
    if (w.has_exp) pending[$] = w.exp;
    in_valid <= 1'b1;
    in_opcode <= w.c.op;
    in_timer_id <= w.c.id;
    in_delay <= w.c.dly;
    in_queue_id <= w.c.q;
    in_payload <= w.c.pl;
    // hold until accepted
    do @(posedge clk); while (in_stall);
    n_items++;
  endtask

  // receiver stall pattern
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 40)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          $error("result with nothing expected: kind %0d", out_kind);
          errors++;
        end else begin
          e = pending.pop_front();
          if (out_kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_kind); errors++;
          end
          if (out_slot !== e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, out_slot); errors++;
          end
          if (out_dest_queue !== e.q) begin
            $error("dest_queue: expected %0d, got %0d", e.q, out_dest_queue); errors++;
          end
          if (out_event_data !== e.data) begin
            $error("event_data: expected %h, got %h", e.data, out_event_data); errors++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_last); errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired, %0d results outstanding", pending.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    row_t w;
    ticks = 0;
    earliest = tdlm_pkg::ALL_ONES;
    head = NT;
    for (int i = 0; i < NT; i++) begin
      status[i] = tdlm_pkg::ST_FREE; dline[i] = 0; nxt[i] = 0; squeue[i] = 0; sdata[i] = '1;
    end
    // directed table
    add_exp(mk(tdlm_pkg::OP_TICK), tdlm_pkg::K_DONE);
    add_exp(mk(3'd5), tdlm_pkg::K_ERROR);
    add_exp(mk(3'd7), tdlm_pkg::K_ERROR);
    add_exp(mk(tdlm_pkg::OP_SETTIME, 5'd3, 32'd1), tdlm_pkg::K_ERROR);
    add_exp(mk(tdlm_pkg::OP_FREE, 5'd9), tdlm_pkg::K_DONE);
    add_exp(mk(tdlm_pkg::OP_ALLOC), tdlm_pkg::K_ALLOC, 5'd0);
    add_exp(mk(tdlm_pkg::OP_ALLOC), tdlm_pkg::K_ALLOC, 5'd1);
    add_exp(mk(tdlm_pkg::OP_ALLOC), tdlm_pkg::K_ALLOC, 5'd2);
    add_exp(mk(tdlm_pkg::OP_SETINFO, 5'd0, 32'd0, 4'hf, 32'h7fffffff), tdlm_pkg::K_DONE);
    add_exp(mk(tdlm_pkg::OP_SETINFO, 5'd1, 32'd0, 4'h0, 32'h80000000), tdlm_pkg::K_DONE);
    add_exp(mk(tdlm_pkg::OP_SETINFO, 5'd31, 32'd0, 4'h5, 32'h0), tdlm_pkg::K_DONE);
    add(mk(tdlm_pkg::OP_SETTIME, 5'd0, 32'd2));
    add(mk(tdlm_pkg::OP_SETTIME, 5'd1, 32'd2));
    // deadline wraps to zero and goes to the head
    add(mk(tdlm_pkg::OP_SETTIME, 5'd2, tdlm_pkg::ALL_ONES));
    add_exp(mk(tdlm_pkg::OP_SETTIME, 5'd0, 32'd5), tdlm_pkg::K_ERROR);
    add(mk(tdlm_pkg::OP_TICK));
    add(mk(tdlm_pkg::OP_TICK));
    add_exp(mk(tdlm_pkg::OP_TICK), tdlm_pkg::K_DONE);
    add_exp(mk(tdlm_pkg::OP_ALLOC), tdlm_pkg::K_ALLOC, 5'd0);
    // head freed before expiry: the next tick passes the earliest-deadline check but finds the list empty
    add(mk(tdlm_pkg::OP_SETTIME, 5'd0, 32'd1));
    add(mk(tdlm_pkg::OP_FREE, 5'd0));
    add_exp(mk(tdlm_pkg::OP_TICK), tdlm_pkg::K_DONE);
    add_exp(mk(tdlm_pkg::OP_TICK), tdlm_pkg::K_DONE);
    for (int i = 0; i < NT; i++) add_exp(mk(tdlm_pkg::OP_ALLOC), tdlm_pkg::K_ALLOC, 5'(i));
    add_exp(mk(tdlm_pkg::OP_ALLOC), tdlm_pkg::K_NOSLOT);
    for (int i = 0; i < NT; i++) add_exp(mk(tdlm_pkg::OP_FREE, 5'(i)), tdlm_pkg::K_DONE);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      gap();
      send(dir_rows[i]);
    end
    // random part, generated as it is sent so delays track the tick count
    for (int i = 0; i < N_RANDOM; i++) begin
      gap();
      w.c = rand_cmd();
      w.has_exp = 1'b0;
      w.exp = '{default: '0};
      send(w);
    end
    in_valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (100) @(posedge clk);
    $display("ran %0d command items (%0d from the directed table) under bursty input",
             n_items, dir_rows.size());
    $display("and random output stalls, %0d timer expiries observed", n_expiries);
    if (errors == 0 && pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
